### src/sorted_key_range_table_unit_macros.svh
// Assertion macros for the sorted key range table unit.
// Used by the top level only; no other dependencies.
`ifndef SORTED_KEY_RANGE_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_RANGE_TABLE_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SKRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/skrt_pkg.sv
// Package for the sorted key range table unit: widths, codes and types.
// No dependencies.
package skrt_pkg;

    localparam int TableDepthDef  = 256;
    localparam int KeyBitsDef     = 32;
    localparam int CommandBitsDef = 16;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_RANGE  = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_DUP     = 3'd2,
        ST_INSIDE  = 3'd3,
        ST_OVERLAP = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SWAIT,
        S_SCHK,
        S_EVAL,
        S_PREV,
        S_PWAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS1,
        S_INS2,
        S_DONE
    } state_t;

    // Payload of one input transfer: mode, key, last_key and command.
    typedef struct packed {
        mode_t                    mode;
        logic [KeyBitsDef-1:0]     key;
        logic [KeyBitsDef-1:0]     last_key;
        logic [CommandBitsDef-1:0] command;
    } request_t;

    // Payload of one result transfer: status, found and matched_command.
    typedef struct packed {
        status_t                   status;
        logic                      found;
        logic [CommandBitsDef-1:0] matched_command;
    } answer_t;

endpackage

### src/skrt_if.sv
// Valid/ready channel interface used for input and result transfers.
// Depends on nothing; payload is a parameterized type.
interface skrt_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/skrt_mem.sv
// Synchronous table memory: one write port and one registered read port.
// Depends on nothing beyond its parameters.
module skrt_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/skrt_ctrl.sv
// Sequencer for the sorted key range table: search, checks, shift, insert.
// Depends on skrt_pkg and drives the skrt_mem ports.
module skrt_ctrl
    import skrt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TableDepthDef,
    parameter int KEY_BITS     = KeyBitsDef,
    parameter int COMMAND_BITS = CommandBitsDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [MODE_W-1:0]             in_mode,
    input  logic [KEY_BITS-1:0]           in_key,
    input  logic [KEY_BITS-1:0]           in_last,
    input  logic [COMMAND_BITS-1:0]       in_cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [STATUS_W-1:0]           out_status,
    output logic                          out_found,
    output logic [COMMAND_BITS-1:0]       out_cmd,
    output logic                          we,
    output logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    output logic [KEY_BITS+COMMAND_BITS-1:0] wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    input  logic [KEY_BITS+COMMAND_BITS-1:0] rdata,
    output logic [$clog2(TABLE_DEPTH):0]   count
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [KEY_BITS-1:0]     last_reg, last_next;
    logic [COMMAND_BITS-1:0] cmd_reg, cmd_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    pass2_reg, pass2_next;
    logic [KEY_BITS-1:0]     skey_reg, skey_next;
    logic [KEY_BITS+COMMAND_BITS-1:0] ent_reg, ent_next;
    logic [STATUS_W-1:0]     st_reg, st_next;
    logic                    fnd_reg, fnd_next;
    logic [COMMAND_BITS-1:0] mc_reg, mc_next;
    logic [CW-1:0]           mid;
    logic [CW-1:0]           gap;
    logic [KEY_BITS-1:0]     rd_key;
    logic [COMMAND_BITS-1:0] rd_cmd, ent_cmd;
    logic [KEY_BITS-1:0]     ent_key;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_key  = rdata[KEY_BITS+COMMAND_BITS-1:COMMAND_BITS];
    assign rd_cmd  = rdata[COMMAND_BITS-1:0];
    assign ent_key = ent_reg[KEY_BITS+COMMAND_BITS-1:COMMAND_BITS];
    assign ent_cmd = ent_reg[COMMAND_BITS-1:0];
    assign gap     = (mode_reg == MODE_RANGE) ? CW'(2) : CW'(1);

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_DONE);
    assign out_status = st_reg;
    assign out_found  = fnd_reg;
    assign out_cmd    = mc_reg;
    assign count      = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        last_reg  <= last_next;
        cmd_reg   <= cmd_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        pass2_reg <= pass2_next;
        skey_reg  <= skey_next;
        ent_reg   <= ent_next;
        st_reg    <= st_next;
        fnd_reg   <= fnd_next;
        mc_reg    <= mc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        last_next  = last_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        pass2_next = pass2_reg;
        skey_next  = skey_reg;
        ent_next   = ent_reg;
        st_next    = st_reg;
        fnd_next   = fnd_reg;
        mc_next    = mc_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr      = mid[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = in_mode;
                    key_next   = in_key;
                    last_next  = in_last;
                    cmd_next   = in_cmd;
                    skey_next  = in_key;
                    pass2_next = 1'b0;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    st_next    = ST_OK;
                    fnd_next   = 1'b0;
                    mc_next    = '0;
                    if (in_mode == MODE_NONE)
                    begin
                        state_next = S_DONE;
                    end
                    else if (in_mode != MODE_LOOKUP && in_cmd == '0)
                    begin
                        st_next    = ST_ZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (hi_reg > lo_reg)
                begin
                    state_next = S_SWAIT;
                end
                else if (lo_reg < cnt_reg)
                begin
                    raddr      = lo_reg[AW-1:0];
                    state_next = S_SCHK;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_SWAIT:
            begin
                if (rd_key < skey_reg)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH;
            end
            S_SCHK:
            begin
                ent_next   = rdata;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!pass2_reg)
                begin
                    pos_next = lo_reg;
                    if (mode_reg == MODE_LOOKUP)
                    begin
                        if (lo_reg < cnt_reg)
                        begin
                            if (ent_cmd == '0 && lo_reg != '0)
                            begin
                                state_next = S_PREV;
                            end
                            else
                            begin
                                if (ent_key == key_reg && ent_cmd != '0)
                                begin
                                    fnd_next = 1'b1;
                                    mc_next  = ent_cmd;
                                end
                                state_next = S_DONE;
                            end
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (lo_reg < cnt_reg && ent_key == key_reg)
                    begin
                        st_next    = ST_DUP;
                        state_next = S_DONE;
                    end
                    else if (lo_reg < cnt_reg && ent_cmd == '0)
                    begin
                        st_next    = ST_INSIDE;
                        state_next = S_DONE;
                    end
                    else if (mode_reg == MODE_RANGE)
                    begin
                        pass2_next = 1'b1;
                        skey_next  = last_reg;
                        lo_next    = '0;
                        hi_next    = cnt_reg;
                        state_next = S_SRCH;
                    end
                    else if (cnt_reg + CW'(1) > CW'(TABLE_DEPTH))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    if (last_reg < key_reg || lo_reg != pos_reg)
                    begin
                        st_next    = ST_OVERLAP;
                        state_next = S_DONE;
                    end
                    else if (lo_reg < cnt_reg && ent_key == last_reg)
                    begin
                        st_next    = ST_DUP;
                        state_next = S_DONE;
                    end
                    else if ({1'b0, cnt_reg} + (CW+1)'(2) > (CW+1)'(TABLE_DEPTH))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_PREV:
            begin
                raddr      = AW'(pos_reg - CW'(1));
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (rd_cmd != '0)
                begin
                    fnd_next = 1'b1;
                    mc_next  = rd_cmd;
                end
                state_next = S_DONE;
            end
            S_SHIFT_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    raddr      = AW'(idx_reg - CW'(1));
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    state_next = S_INS1;
                end
            end
            S_SHIFT_WR:
            begin
                we         = 1'b1;
                waddr      = AW'(idx_reg - CW'(1) + gap);
                wdata      = rdata;
                idx_next   = idx_reg - CW'(1);
                state_next = S_SHIFT_RD;
            end
            S_INS1:
            begin
                we    = 1'b1;
                waddr = pos_reg[AW-1:0];
                wdata = {key_reg, cmd_reg};
                if (mode_reg == MODE_RANGE)
                begin
                    state_next = S_INS2;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_INS2:
            begin
                we         = 1'b1;
                waddr      = AW'(pos_reg + CW'(1));
                wdata      = {last_reg, {COMMAND_BITS{1'b0}}};
                cnt_next   = cnt_reg + CW'(2);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

### src/sorted_key_range_table_unit.sv
// Sorted key range table unit: one item in flight, result held until taken.
// Lookup: a binary search over the single read port, then a check of the entry found
// and, when that entry ends a range, of the entry before it.
// Add: search (twice for a range), then each entry moved is read and then written,
// then the insert. Reset clears the state and the entry count only; table contents
// stay undefined and are never read unwritten.
`include "sorted_key_range_table_unit_macros.svh"
module sorted_key_range_table_unit
    import skrt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TableDepthDef,
    parameter int KEY_BITS     = KeyBitsDef,
    parameter int COMMAND_BITS = CommandBitsDef
) (
    input logic clk,
    input logic rst_n,
    skrt_if.sink   in_ch,
    skrt_if.source out_ch
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = KEY_BITS + COMMAND_BITS;
    localparam logic [AW:0] CountMax = (AW+1)'(TABLE_DEPTH);

    // The input payload carries mode, key, last_key and command in that order;
    // the result payload carries status, found and matched_command.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [AW:0]   count;
    logic          res_found;
    logic          res_cmd_zero;

    // Each entry holds a key in its upper bits and its command id below.
    // A command id of zero marks the last key of a range.
    skrt_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The sequencer does the binary search, the add checks, the upward shift
    // that opens a gap (each entry is read, then written higher up), and the insert.
    skrt_ctrl #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .COMMAND_BITS (COMMAND_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_mode    (in_ch.payload.mode),
        .in_key     (in_ch.payload.key[KEY_BITS-1:0]),
        .in_last    (in_ch.payload.last_key[KEY_BITS-1:0]),
        .in_cmd     (in_ch.payload.command[COMMAND_BITS-1:0]),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_status (out_ch.payload.status),
        .out_found  (out_ch.payload.found),
        .out_cmd    (out_ch.payload.matched_command),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .raddr      (raddr),
        .rdata      (rdata),
        .count      (count)
    );

    assign res_found    = out_ch.valid && out_ch.payload.found;
    assign res_cmd_zero = (out_ch.payload.matched_command == '0);

    // The count never exceeds the table depth.
    `SKRT_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count <= CountMax, "count overflow")
    // No new transfer is taken while a result waits.
    `SKRT_ASSERT_IMP(a_one_item, clk, rst_n, out_ch.valid, !in_ch.ready, "overlap of items")
    // A found lookup always carries a nonzero command.
    `SKRT_ASSERT_IMP(a_found_cmd, clk, rst_n, res_found, !res_cmd_zero, "found without command")
    // The count only changes while no result is shown.
    `SKRT_ASSERT_NEXT(a_count_hold, clk, rst_n, out_ch.valid, $stable(count), "count moved")
endmodule

### tb/sorted_key_range_table_unit_test.sv
// Testbench for the sorted key range table unit: directed and random adds,
// range adds and lookups, checked against an in-bench table predictor.
// Depends on skrt_pkg, the skrt_if channel interface and the unit itself.
`timescale 1ns / 1ps
module sorted_key_range_table_unit_test
    import skrt_pkg::*;
();

    localparam int DEPTH      = TableDepthDef;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;

    skrt_if #(.payload_t(request_t)) in_ch (clk);
    skrt_if #(.payload_t(answer_t))  out_ch (clk);

    sorted_key_range_table_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Shadow copy of the table: sorted keys, their commands and the fill level.
    logic [31:0] shadow_key [DEPTH];
    logic [15:0] shadow_cmd [DEPTH];
    int          shadow_count;

    answer_t pending_answers[$];
    int      error_count;
    int      idle_cycles = 0;
    int      sent_count;
    int      checked_count;
    int      burst_left;
    bit      gaps_on;
    bit      stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Index of the first entry whose key is not below k.
    function automatic int lower_bound(logic [31:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count;
        while (hi > lo)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_key[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return hi;
    endfunction

    // True when a single key add of k would neither duplicate nor land in a range.
    function automatic bit key_is_free(logic [31:0] k);
        int pos;
        pos = lower_bound(k);
        return !(pos < shadow_count && (shadow_key[pos] == k || shadow_cmd[pos] == 16'd0));
    endfunction

    // Shift entries at pos and above up by n to make room.
    function automatic void make_room(int pos, int n);
        for (int i = shadow_count - 1; i >= pos; i--)
        begin
            shadow_key[i + n] = shadow_key[i];
            shadow_cmd[i + n] = shadow_cmd[i];
        end
    endfunction

    // Works out the answer to one request and updates the shadow table.
    function automatic answer_t table_answer(request_t r);
        answer_t a;
        int      pos;
        int      pos2;
        logic [15:0] c;
        a = '0;
        a.status = ST_OK;
        pos = 0;
        if (r.mode == MODE_ADD || r.mode == MODE_RANGE)
        begin
            if (r.command == 16'd0)
                a.status = ST_ZERO;
            else
            begin
                pos = lower_bound(r.key);
                if (pos < shadow_count && shadow_key[pos] == r.key)
                    a.status = ST_DUP;
                else if (pos < shadow_count && shadow_cmd[pos] == 16'd0)
                    a.status = ST_INSIDE;
            end
            if (a.status == ST_OK && r.mode == MODE_ADD)
            begin
                if (shadow_count + 1 > DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    make_room(pos, 1);
                    shadow_key[pos] = r.key;
                    shadow_cmd[pos] = r.command;
                    shadow_count += 1;
                end
            end
            else if (a.status == ST_OK)
            begin
                pos2 = lower_bound(r.last_key);
                if (r.last_key < r.key || pos != pos2)
                    a.status = ST_OVERLAP;
                else if (pos2 < shadow_count && shadow_key[pos2] == r.last_key)
                    a.status = ST_DUP;
                else if (shadow_count + 2 > DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    make_room(pos, 2);
                    shadow_key[pos]     = r.key;
                    shadow_cmd[pos]     = r.command;
                    shadow_key[pos + 1] = r.last_key;
                    shadow_cmd[pos + 1] = 16'd0;
                    shadow_count += 2;
                end
            end
        end
        else if (r.mode == MODE_LOOKUP)
        begin
            pos = lower_bound(r.key);
            if (pos < shadow_count)
            begin
                c = 16'd0;
                if (shadow_cmd[pos] == 16'd0 && pos > 0)
                    c = shadow_cmd[pos - 1];
                else if (shadow_key[pos] == r.key)
                    c = shadow_cmd[pos];
                if (c != 16'd0)
                begin
                    a.found = 1'b1;
                    a.matched_command = c;
                end
            end
        end
        return a;
    endfunction

    // Sends one request; the caller is always at a rising edge. Valid stays
    // high after the transfer so back-to-back requests need no second write.
    task automatic send_request(mode_t m, logic [31:0] k, logic [31:0] last,
                                logic [15:0] cmd);
        request_t r;
        r.mode = m;
        r.key = k;
        r.last_key = last;
        r.command = cmd;
        if (gaps_on && burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_answers.push_back(table_answer(r));
        sent_count++;
    endtask

    // Holds the sender off until every outstanding answer has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(MODE_ADD, 32'd10, 32'd0, 16'd0);               // zero command
        send_request(MODE_ADD, 32'h0000_0000, 32'd0, 16'hFFFF);
        send_request(MODE_ADD, 32'hFFFF_FFFF, 32'd0, 16'h0001);
        send_request(MODE_ADD, 32'h0000_0000, 32'd0, 16'h0002);     // duplicate
        send_request(MODE_RANGE, 32'd100, 32'd200, 16'h0005);
        send_request(MODE_ADD, 32'd150, 32'd0, 16'h0007);           // inside range
        send_request(MODE_ADD, 32'd200, 32'd0, 16'h0007);           // equals range end
        send_request(MODE_RANGE, 32'd50, 32'd300, 16'h0009);        // spans a range
        send_request(MODE_RANGE, 32'd300, 32'd250, 16'h0009);       // reversed
        send_request(MODE_RANGE, 32'd90, 32'd100, 16'h0009);        // last key exists
        send_request(MODE_RANGE, 32'd0, 32'd5, 16'h0009);           // first key exists
        send_request(MODE_RANGE, 32'd500, 32'd500, 16'hAAAA);       // single-key range
        send_request(MODE_RANGE, 32'd120, 32'd130, 16'h0003);       // first key inside
        send_request(MODE_LOOKUP, 32'd150, 32'd0, 16'd0);
        send_request(MODE_LOOKUP, 32'd100, 32'd0, 16'd0);
        send_request(MODE_LOOKUP, 32'd200, 32'd0, 16'd0);
        send_request(MODE_LOOKUP, 32'd0, 32'd0, 16'd0);
        send_request(MODE_LOOKUP, 32'd1, 32'd0, 16'd0);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'd0, 16'd0);
        send_request(MODE_LOOKUP, 32'd500, 32'd0, 16'd0);
        send_request(MODE_LOOKUP, 32'd201, 32'd0, 16'd0);
        send_request(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        drain();
    endtask

    // Keys come mostly from a narrow window so duplicates, hits and
    // overlaps are common; the rest span the whole key space.
    task automatic test_random(int n);
        logic [31:0] k;
        logic [31:0] last;
        logic [15:0] cmd;
        int          pick;
        for (int i = 0; i < n; i++)
        begin
            k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
            last = ($urandom_range(0, 4) == 0) ? $urandom : k + $urandom_range(0, 40);
            cmd = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 16'hFFFF));
            pick = $urandom_range(0, 19);
            if (pick < 6)
                send_request(MODE_ADD, k, last, cmd);
            else if (pick < 10)
                send_request(MODE_RANGE, k, last, cmd);
            else if (pick < 19)
                send_request(MODE_LOOKUP, k, last, cmd);
            else
            begin
                send_request(MODE_NONE, k, last, cmd);
                i--;
            end
            if (i == n / 2)
            begin
                stalls_on = 1'b0;
                gaps_on = 1'b0;
            end
            if (i == 3 * n / 4)
            begin
                stalls_on = 1'b1;
                gaps_on = 1'b1;
            end
        end
        drain();
    endtask

    // Fills the table to one below capacity, then pushes it past full.
    task automatic test_full();
        logic [31:0] k;
        int          tries;
        int          guard;
        guard = 0;
        while (shadow_count < DEPTH - 1 && guard < 2 * DEPTH)
        begin
            tries = 0;
            do
            begin
                k = $urandom;
                tries++;
            end
            while (!key_is_free(k) && tries < 1000);
            send_request(MODE_ADD, k, 32'd0, 16'($urandom_range(1, 16'hFFFF)));
            guard++;
        end
        send_request(MODE_RANGE, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 16'h1234);
        send_request(MODE_ADD, 32'h7FFF_FFF1, 32'd0, 16'h1235);
        send_request(MODE_ADD, 32'h7FFF_FFF2, 32'd0, 16'h1236);
        send_request(MODE_RANGE, 32'h7FFF_FFF3, 32'h7FFF_FFF4, 16'h1237);
        for (int i = 0; i < 10; i++)
            send_request(MODE_LOOKUP,
                         (i < 5) ? $urandom : shadow_key[$urandom_range(0, shadow_count - 1)],
                         32'd0, 16'd0);
        drain();
    endtask

    // Result side: stall pattern plus the field-by-field comparison.
    always @(posedge clk)
    begin
        answer_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            out_ch.ready <= stalls_on ? ($urandom_range(0, 3) != 0) : 1'b1;
            if (out_ch.valid && out_ch.ready)
            begin
                checked_count++;
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_ch.payload);
                    error_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (out_ch.payload.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, out_ch.payload.status);
                        error_count++;
                    end
                    if (out_ch.payload.found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d", $time,
                                 want.found, out_ch.payload.found);
                        error_count++;
                    end
                    if (out_ch.payload.matched_command !== want.matched_command)
                    begin
                        $display("%0t: matched_command expected %h actual %h", $time,
                                 want.matched_command, out_ch.payload.matched_command);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: any transfer on either channel resets the idle count.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        shadow_count = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(250);
        test_full();
        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_answers.size());
            error_count++;
        end
        $display("Sent %0d requests, checked %0d results; table ended with %0d entries.",
                 sent_count, checked_count, shadow_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
+incdir+src
src/skrt_pkg.sv
src/skrt_if.sv
src/skrt_mem.sv
src/skrt_ctrl.sv
src/sorted_key_range_table_unit.sv
tb/sorted_key_range_table_unit_test.sv
